// ===== rtl/mfap_pkg.sv =====
// ----------------------------------------------------------------------------
// mfap_pkg
// Shared types and codes of the max flow augmenting path unit.
// ----------------------------------------------------------------------------
package mfap_pkg;

   // Input transaction: one directed edge
   typedef struct packed {
      logic [5:0]  edge_tail;
      logic [5:0]  edge_head;
      logic [30:0] edge_capacity;
      logic        last_edge;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [30:0] total_flow;
      logic        flow_saturated;
      logic        edges_dropped;
   } rsp_type;

   // Register indexes
   localparam logic CSR_SOURCE = 1'b0;
   localparam logic CSR_SINK   = 1'b1;

   // Largest reportable total
   localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LD_CHK,
      ST_LD_A,
      ST_LD_B,
      ST_FIN,
      ST_START,
      ST_HEAD,
      ST_SCAN,
      ST_EVAL,
      ST_POP,
      ST_POPR,
      ST_POPN,
      ST_AUG,
      ST_AUG_C,
      ST_AUG_R,
      ST_AUG_S,
      ST_AUG_A,
      ST_TOTAL,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/max_flow_augmenting_path_unit.sv =====
// ----------------------------------------------------------------------------
// max_flow_augmenting_path_unit
// Edge load: busy after the accept cycle for a check, then LD_A and LD_B per
// slot; a dropped edge ends after the check. Flow search: SCAN and EVAL per edge
// examined, HEAD per push, POP, POPR and (if edges remain) POPN per pop, AUG to
// AUG_A per path edge (no AUG_C for the last), on one-read one-write memories.
// Result strobe follows the last search; receiver cannot stall it. Synchronous
// reset clears lists, counters and control registers (source 0, sink 1).
// ----------------------------------------------------------------------------
module max_flow_augmenting_path_unit #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256,
   parameter int CAP_BITS     = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mfap_pkg::req_type req_data,
   output logic             rsp_valid,
   output mfap_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [5:0]       csr_wdata
);

   localparam int SLOTS  = 2 * MAX_EDGES;
   localparam int IW     = $clog2(SLOTS);
   localparam int EW     = $clog2(SLOTS + 1);
   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int SDEPTH = MAX_VERTICES + 1;
   localparam int SAW    = $clog2(SDEPTH);
   localparam int SPW    = $clog2(SDEPTH + 1);
   localparam int TW     = ((CAP_BITS > 31) ? CAP_BITS : 31) + 1;
   localparam int FW     = VW + EW + CAP_BITS;
   localparam logic [EW-1:0]       NULL_EDGE = EW'(SLOTS);
   localparam logic [CAP_BITS-1:0] CAP_MASK  = {CAP_BITS{1'b1}};

   // Control and datapath registers
   mfap_pkg::state_type state_ff, state_in;
   logic [5:0]              src_ff, src_in, snk_ff, snk_in;
   mfap_pkg::req_type       req_ff, req_in;
   logic                    slot_ff, slot_in;
   logic [EW-1:0]           cnt_ff, cnt_in;
   logic                    drop_ff, drop_in;
   logic [MAX_VERTICES-1:0] vld_ff, vld_in, vis_ff, vis_in;
   logic [VW-1:0]           vtx_ff, vtx_in;
   logic [EW-1:0]           cur_ff, cur_in;
   logic [CAP_BITS-1:0]     bn_ff, bn_in, d_ff, d_in;
   logic [SPW-1:0]          sp_ff, sp_in, k_ff, k_in;
   logic [IW-1:0]           c_ff, c_in;
   logic [30:0]             total_ff, total_in;
   logic                    sat_ff, sat_in;

   // Memories and their registered read data
   logic [VW-1:0]       tgt_mem [SLOTS];
   logic [CAP_BITS-1:0] res_mem [SLOTS];
   logic [EW-1:0]       nxt_mem [SLOTS];
   logic [EW-1:0]       head_mem [MAX_VERTICES];
   logic [EW-1:0]       tail_mem [MAX_VERTICES];
   logic [FW-1:0]       stk_mem [SDEPTH];
   logic [VW-1:0]       tgt_rd_ff;
   logic [CAP_BITS-1:0] res_rd_ff;
   logic [EW-1:0]       nxt_rd_ff, head_rd_ff, tail_rd_ff;
   logic [FW-1:0]       stk_rd_ff;

   // Memory ports
   logic                tgt_we, res_we, nxt_we, head_we, tail_we, stk_we;
   logic [IW-1:0]       edge_ra, res_ra, nxt_ra, tgt_wa, res_wa, nxt_wa;
   logic [VW-1:0]       tgt_wd, head_wa, head_ra, tail_wa, tail_ra;
   logic [CAP_BITS-1:0] res_wd;
   logic [EW-1:0]       nxt_wd, head_wd, tail_wd;
   logic [SAW-1:0]      stk_wa, stk_ra;
   logic [FW-1:0]       stk_wd;

   // Helper terms
   logic                ld_drop, run_ok, e_hit, to_sink;
   logic [VW-1:0]       ld_from, ld_to;
   logic [CAP_BITS-1:0] ld_cap, d_min;
   logic [VW-1:0]       fr_vtx;
   logic [EW-1:0]       fr_cur;
   logic [CAP_BITS-1:0] fr_bn;
   logic [TW-1:0]       sum;

   assign ld_drop = (32'(req_ff.edge_tail) >= 32'(MAX_VERTICES)) ||
                    (32'(req_ff.edge_head) >= 32'(MAX_VERTICES)) ||
                    (32'(cnt_ff) + 32'd2 > 32'(SLOTS));
   assign ld_from = slot_ff ? VW'(req_ff.edge_head) : VW'(req_ff.edge_tail);
   assign ld_to   = slot_ff ? VW'(req_ff.edge_tail) : VW'(req_ff.edge_head);
   assign ld_cap  = slot_ff ? '0 : CAP_BITS'(req_ff.edge_capacity);
   assign run_ok  = (src_ff != snk_ff) && (32'(src_ff) < 32'(MAX_VERTICES)) &&
                    (32'(snk_ff) < 32'(MAX_VERTICES));
   assign e_hit   = (res_rd_ff != '0) && !vis_ff[tgt_rd_ff];
   assign to_sink = 32'(tgt_rd_ff) == 32'(snk_ff);
   assign d_min   = (bn_ff < res_rd_ff) ? bn_ff : res_rd_ff;
   assign fr_vtx  = stk_rd_ff[FW-1 -: VW];
   assign fr_cur  = stk_rd_ff[CAP_BITS +: EW];
   assign fr_bn   = stk_rd_ff[CAP_BITS-1:0];
   assign sum     = TW'(total_ff) + TW'(d_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfap_pkg::ST_IDLE: begin
            if (start) state_in = mfap_pkg::ST_LD_CHK;
         end
         mfap_pkg::ST_LD_CHK: begin
            if (!ld_drop) state_in = mfap_pkg::ST_LD_A;
            else if (req_ff.last_edge) state_in = mfap_pkg::ST_FIN;
            else state_in = mfap_pkg::ST_IDLE;
         end
         mfap_pkg::ST_LD_A: state_in = mfap_pkg::ST_LD_B;
         mfap_pkg::ST_LD_B: begin
            if (!slot_ff) state_in = mfap_pkg::ST_LD_A;
            else if (req_ff.last_edge) state_in = mfap_pkg::ST_FIN;
            else state_in = mfap_pkg::ST_IDLE;
         end
         mfap_pkg::ST_FIN: state_in = run_ok ? mfap_pkg::ST_START : mfap_pkg::ST_OUT;
         mfap_pkg::ST_START: state_in = mfap_pkg::ST_HEAD;
         mfap_pkg::ST_HEAD: state_in = mfap_pkg::ST_SCAN;
         mfap_pkg::ST_SCAN: begin
            state_in = (cur_ff >= cnt_ff) ? mfap_pkg::ST_POP : mfap_pkg::ST_EVAL;
         end
         mfap_pkg::ST_EVAL: begin
            if (!e_hit) state_in = mfap_pkg::ST_SCAN;
            else if (to_sink) state_in = mfap_pkg::ST_AUG;
            else state_in = mfap_pkg::ST_HEAD;
         end
         mfap_pkg::ST_POP: begin
            state_in = (sp_ff == SPW'(1)) ? mfap_pkg::ST_OUT : mfap_pkg::ST_POPR;
         end
         mfap_pkg::ST_POPR: begin
            state_in = (fr_cur < cnt_ff) ? mfap_pkg::ST_POPN : mfap_pkg::ST_SCAN;
         end
         mfap_pkg::ST_POPN: state_in = mfap_pkg::ST_SCAN;
         mfap_pkg::ST_AUG: begin
            state_in = ((k_ff + SPW'(1)) < sp_ff) ? mfap_pkg::ST_AUG_C
                                                  : mfap_pkg::ST_AUG_R;
         end
         mfap_pkg::ST_AUG_C: state_in = mfap_pkg::ST_AUG_R;
         mfap_pkg::ST_AUG_R: state_in = mfap_pkg::ST_AUG_S;
         mfap_pkg::ST_AUG_S: state_in = mfap_pkg::ST_AUG_A;
         mfap_pkg::ST_AUG_A: begin
            state_in = ((k_ff + SPW'(1)) == sp_ff) ? mfap_pkg::ST_TOTAL
                                                   : mfap_pkg::ST_AUG;
         end
         mfap_pkg::ST_TOTAL: state_in = mfap_pkg::ST_START;
         mfap_pkg::ST_OUT: state_in = mfap_pkg::ST_IDLE;
         default: state_in = mfap_pkg::ST_IDLE;
      endcase
   end

   // Outputs and memory port controls
   always_comb begin
      busy      = state_ff != mfap_pkg::ST_IDLE;
      rsp_valid = state_ff == mfap_pkg::ST_OUT;
      rsp_data.total_flow     = total_ff;
      rsp_data.flow_saturated = sat_ff;
      rsp_data.edges_dropped  = drop_ff;
      tgt_we  = 1'b0;
      res_we  = 1'b0;
      nxt_we  = 1'b0;
      head_we = 1'b0;
      tail_we = 1'b0;
      stk_we  = 1'b0;
      edge_ra = cur_ff[IW-1:0];
      res_ra  = cur_ff[IW-1:0];
      nxt_ra  = cur_ff[IW-1:0];
      tgt_wa  = cnt_ff[IW-1:0];
      tgt_wd  = ld_to;
      res_wa  = cnt_ff[IW-1:0];
      res_wd  = ld_cap;
      nxt_wa  = cnt_ff[IW-1:0];
      nxt_wd  = NULL_EDGE;
      head_wa = ld_from;
      head_wd = cnt_ff;
      head_ra = VW'(src_ff);
      tail_wa = ld_from;
      tail_wd = cnt_ff;
      tail_ra = ld_from;
      stk_wa  = SAW'(sp_ff - SPW'(1));
      stk_wd  = {vtx_ff, cur_ff, bn_ff};
      stk_ra  = SAW'(k_ff);
      unique case (state_ff)
         mfap_pkg::ST_LD_A: begin
            tgt_we = 1'b1;
            res_we = 1'b1;
            nxt_we = 1'b1;
         end
         mfap_pkg::ST_LD_B: begin
            tail_we = 1'b1;
            if (vld_ff[ld_from]) begin
               nxt_we = 1'b1;
               nxt_wa = tail_rd_ff[IW-1:0];
               nxt_wd = cnt_ff;
            end else begin
               head_we = 1'b1;
            end
         end
         mfap_pkg::ST_EVAL: begin
            head_ra = tgt_rd_ff;
            if (e_hit && !to_sink) stk_we = 1'b1;
         end
         mfap_pkg::ST_POP: stk_ra = SAW'(sp_ff - SPW'(2));
         mfap_pkg::ST_POPR: nxt_ra = fr_cur[IW-1:0];
         mfap_pkg::ST_AUG_R: res_ra = c_ff;
         mfap_pkg::ST_AUG_S: begin
            res_we = 1'b1;
            res_wa = c_ff;
            res_wd = res_rd_ff - d_ff;
            res_ra = c_ff ^ IW'(1);
         end
         mfap_pkg::ST_AUG_A: begin
            res_we = 1'b1;
            res_wa = c_ff ^ IW'(1);
            res_wd = res_rd_ff + d_ff;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      src_in   = src_ff;
      snk_in   = snk_ff;
      req_in   = req_ff;
      slot_in  = slot_ff;
      cnt_in   = cnt_ff;
      drop_in  = drop_ff;
      vld_in   = vld_ff;
      vis_in   = vis_ff;
      vtx_in   = vtx_ff;
      cur_in   = cur_ff;
      bn_in    = bn_ff;
      sp_in    = sp_ff;
      k_in     = k_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      total_in = total_ff;
      sat_in   = sat_ff;
      if (csr_we && csr_index == mfap_pkg::CSR_SOURCE) src_in = csr_wdata;
      if (csr_we && csr_index == mfap_pkg::CSR_SINK) snk_in = csr_wdata;
      case (state_ff)
         mfap_pkg::ST_IDLE: begin
            if (start) begin
               req_in  = req_data;
               slot_in = 1'b0;
            end
         end
         mfap_pkg::ST_LD_CHK: begin
            if (ld_drop) drop_in = 1'b1;
         end
         mfap_pkg::ST_LD_B: begin
            vld_in[ld_from] = 1'b1;
            cnt_in  = cnt_ff + EW'(1);
            slot_in = 1'b1;
         end
         mfap_pkg::ST_START: begin
            vis_in = '0;
            vis_in[VW'(src_ff)] = 1'b1;
            vtx_in = VW'(src_ff);
            bn_in  = CAP_MASK;
            sp_in  = SPW'(1);
         end
         mfap_pkg::ST_HEAD: cur_in = vld_ff[vtx_ff] ? head_rd_ff : NULL_EDGE;
         mfap_pkg::ST_EVAL: begin
            if (!e_hit) begin
               cur_in = nxt_rd_ff;
            end else begin
               d_in = d_min;
               k_in = '0;
               if (!to_sink) begin
                  vis_in[tgt_rd_ff] = 1'b1;
                  vtx_in = tgt_rd_ff;
                  bn_in  = d_min;
                  sp_in  = sp_ff + SPW'(1);
               end
            end
         end
         mfap_pkg::ST_POP: sp_in = sp_ff - SPW'(1);
         mfap_pkg::ST_POPR: begin
            vtx_in = fr_vtx;
            cur_in = fr_cur;
            bn_in  = fr_bn;
         end
         mfap_pkg::ST_POPN: cur_in = nxt_rd_ff;
         mfap_pkg::ST_AUG: c_in = cur_ff[IW-1:0];
         mfap_pkg::ST_AUG_C: c_in = fr_cur[IW-1:0];
         mfap_pkg::ST_AUG_A: k_in = k_ff + SPW'(1);
         mfap_pkg::ST_TOTAL: begin
            if (sum > TW'(mfap_pkg::OUT_MAX)) begin
               total_in = mfap_pkg::OUT_MAX;
               sat_in   = 1'b1;
            end else begin
               total_in = sum[30:0];
            end
         end
         mfap_pkg::ST_OUT: begin
            vld_in   = '0;
            cnt_in   = '0;
            drop_in  = 1'b0;
            total_in = '0;
            sat_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfap_pkg::ST_IDLE;
         src_ff   <= 6'd0;
         snk_ff   <= 6'd1;
         slot_ff  <= 1'b0;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         vld_ff   <= '0;
         vis_ff   <= '0;
         sp_ff    <= '0;
         k_ff     <= '0;
         total_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
         snk_ff   <= snk_in;
         slot_ff  <= slot_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         vld_ff   <= vld_in;
         vis_ff   <= vis_in;
         sp_ff    <= sp_in;
         k_ff     <= k_in;
         total_ff <= total_in;
         sat_ff   <= sat_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      vtx_ff <= vtx_in;
      cur_ff <= cur_in;
      bn_ff  <= bn_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
   end

   // Residual edge table
   always_ff @(posedge clock) begin
      if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
      tgt_rd_ff <= tgt_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (res_we) res_mem[res_wa] <= res_wd;
      res_rd_ff <= res_mem[res_ra];
   end

   always_ff @(posedge clock) begin
      if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
      nxt_rd_ff <= nxt_mem[nxt_ra];
   end

   // Per-vertex list heads and tails, qualified by vld_ff
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      head_rd_ff <= head_mem[head_ra];
   end

   always_ff @(posedge clock) begin
      if (tail_we) tail_mem[tail_wa] <= tail_wd;
      tail_rd_ff <= tail_mem[tail_ra];
   end

   // Search stack, frames below the top one
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      stk_rd_ff <= stk_mem[stk_ra];
   end

   // Checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_graph_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (cnt_ff == '0) && !drop_ff && (vld_ff == '0))
      else $error("graph not cleared after result");

   a_slots_paired: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mfap_pkg::ST_IDLE) |-> (!cnt_ff[0] && (cnt_ff <= EW'(SLOTS))))
      else $error("edge count not paired");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) <= 32'(MAX_VERTICES))
      else $error("search stack overflow");

endmodule
